// ----- hdl/mscf_pkg.sv -----
`default_nettype none
package mscf_pkg;

  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [3:0] LAST_POS      = 4'd9;
  localparam logic [3:0] FAULT_POS     = 4'd8;
  localparam logic [3:0] MODE_POS      = 4'd1;
  localparam logic [3:0] ID_POS        = 4'd0;
  localparam logic [7:0] MODE_CURRENT  = 8'h01;
  localparam logic [7:0] MODE_SPEED    = 8'h02;
  localparam logic [7:0] MODE_POSITION = 8'h03;
  localparam logic [3:0] POS_NONE      = 4'd0;
  localparam logic [3:0] POS_CURRENT   = 4'd2;
  localparam logic [3:0] POS_SPEED     = 4'd4;
  localparam logic [3:0] POS_POSITION  = 4'd6;
  localparam logic [7:0] ID_RESET      = 8'h01;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ID_ERR   = 2'd1,
    ST_MODE_ERR = 2'd2,
    ST_CRC_ERR  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  fault_code;
    logic [15:0] loop_value;
    logic [7:0]  mode;
    status_t     status;
  } result_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] b_in);
    logic [7:0] crc;
    logic [7:0] b;
    logic       fb;
    crc = crc_in;
    b   = b_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ b[0];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  function automatic logic [3:0] value_pos(input logic [7:0] m);
    case (m)
      MODE_CURRENT:  value_pos = POS_CURRENT;
      MODE_SPEED:    value_pos = POS_SPEED;
      MODE_POSITION: value_pos = POS_POSITION;
      default:       value_pos = POS_NONE;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mscf_frame.sv -----
`default_nettype none
module mscf_frame
  import mscf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output logic            res_valid,
  output result_t         res
);

  logic [7:0]  expected_id_r;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  crc_acc_r, crc_acc_nxt;
  logic        id_matched_r, id_matched_nxt;
  logic [7:0]  mode_held_r, mode_held_nxt;
  logic [15:0] value_held_r, value_held_nxt;
  logic [7:0]  fault_held_r, fault_held_nxt;

  logic [3:0]  pos;
  logic [7:0]  crc_base, mode_base;
  logic        id_base;
  logic [15:0] value_base;
  logic [7:0]  fault_base;
  logic [3:0]  vp;
  logic        active;

  always_comb begin
    active     = step && (frame_start || in_frame_r);
    pos        = frame_start ? 4'd0 : byte_index_r;
    crc_base   = frame_start ? 8'd0 : crc_acc_r;
    id_base    = frame_start ? 1'b0 : id_matched_r;
    mode_base  = frame_start ? 8'd0 : mode_held_r;
    value_base = frame_start ? 16'd0 : value_held_r;
    fault_base = frame_start ? 8'd0 : fault_held_r;
    vp         = value_pos(mode_base);

    byte_index_nxt = byte_index_r;
    in_frame_nxt   = in_frame_r;
    crc_acc_nxt    = crc_acc_r;
    id_matched_nxt = id_matched_r;
    mode_held_nxt  = mode_held_r;
    value_held_nxt = value_held_r;
    fault_held_nxt = fault_held_r;

    res_valid       = 1'b0;
    res.mode        = mode_base;
    res.fault_code  = fault_base;
    res.loop_value  = (vp != POS_NONE) ? value_base : 16'd0;
    if (!id_base) begin
      res.status = ST_ID_ERR;
    end else if (vp == POS_NONE) begin
      res.status = ST_MODE_ERR;
    end else if (crc_base != rx_byte) begin
      res.status = ST_CRC_ERR;
    end else begin
      res.status = ST_OK;
    end

    if (active) begin
      crc_acc_nxt    = crc_base;
      id_matched_nxt = id_base;
      mode_held_nxt  = mode_base;
      value_held_nxt = value_base;
      fault_held_nxt = fault_base;
      if (pos >= LAST_POS) begin
        res_valid      = 1'b1;
        in_frame_nxt   = 1'b0;
        byte_index_nxt = 4'd0;
      end else begin
        in_frame_nxt   = 1'b1;
        byte_index_nxt = pos + 4'd1;
        crc_acc_nxt    = crc_feed(crc_base, rx_byte);
        if (pos == ID_POS) begin
          id_matched_nxt = (rx_byte == expected_id_r);
        end else if (pos == MODE_POS) begin
          mode_held_nxt = rx_byte;
        end else if (pos == FAULT_POS) begin
          fault_held_nxt = rx_byte;
        end else if (vp != POS_NONE && (pos == vp || pos == vp + 4'd1)) begin
          value_held_nxt = {value_base[7:0], rx_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= ID_RESET;
      byte_index_r  <= 4'd0;
      in_frame_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_id_r <= cfg_data;
      end
      byte_index_r <= byte_index_nxt;
      in_frame_r   <= in_frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_acc_r    <= crc_acc_nxt;
    id_matched_r <= id_matched_nxt;
    mode_held_r  <= mode_held_nxt;
    value_held_r <= value_held_nxt;
    fault_held_r <= fault_held_nxt;
  end

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= LAST_POS)
    else $error("byte index past last position");
  a_closed_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> byte_index_r == 4'd0)
    else $error("index nonzero with no open frame");
  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !in_frame_r)
    else $error("frame still open after result");
`endif

endmodule
`default_nettype wire

// ----- hdl/mscf_out_buf.sv -----
`default_nettype none
module mscf_out_buf
  import mscf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_accept,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output result_t      pop_data
);

  logic    main_valid_r, skid_valid_r;
  result_t main_data_r, skid_data_r;
  logic    pop;

  assign pop        = main_valid_r && pop_ready;
  assign can_accept = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held with empty main stage");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("word pushed into full buffer");
`endif

endmodule
`default_nettype wire

// ----- hdl/motor_status_frame_checker.sv -----
`default_nettype none
// Checks ten-byte motor status frames fed one byte per input word; in_tuser[0] marks byte 0
// and restarts the frame, and bytes outside an open frame are dropped. Byte 0 is compared
// with expected_id (reset 1, to be written on the cfg port only while idle, not enforced by the
// block; takes effect at the next frame), byte 1 is the mode, the big-endian value comes from
// bytes 2-3, 4-5 or 6-7 for mode 1, 2 or 3, byte 8 is the fault code, and byte 9 is compared
// with a reflected CRC-8 (polynomial 0x8C, init 0) over bytes 0 to 8. Byte 9 yields one result
// word, status priority identifier, mode, CRC. One byte is taken every cycle while in_tready is
// high; the result is registered in a two-word output buffer, which keeps input flowing while
// the sink stalls until both words are held, then holds in_tready low until the sink takes a word.
module motor_status_frame_checker
  import mscf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,    // expected_id
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,    // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata    // [1:0] status, [9:2] mode, [25:10] loop_value,
                                        // [33:26] fault_code, [39:34] zero
);

  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign step      = in_tvalid && in_tready;

  mscf_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .step        (step),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser[0]),
    .res_valid   (res_valid),
    .res         (res)
  );

  mscf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_res)
  );

  assign out_tdata = {6'd0, out_res};

endmodule
`default_nettype wire
